[rtl/mzg_pkg.sv]
// ----------------------------------------------------------------------------
// mzg_pkg
// shared types and constants of the depth-first maze generator
// ----------------------------------------------------------------------------
package mzg_pkg;

    // carving directions, two cells a step
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    // direction order, entry 0 in the low bits
    typedef logic [3:0][1:0] t_order;

    localparam t_order ORDER_RESET = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

    // galois lfsr feedback mask
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // control toward the shuffle unit
    typedef struct packed {
        logic load;   // take a new seed
        logic mix;    // four draws and swaps on the order
    } t_shuf_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STEP,
        ST_CHECK,
        ST_MID,
        ST_POP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

endpackage

[rtl/mzg_shuffle.sv]
// ----------------------------------------------------------------------------
// mzg_shuffle
// random generator and shared direction order, reshuffled on cell entry
// ----------------------------------------------------------------------------
module mzg_shuffle (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mzg_pkg::t_shuf_ctrl i_ctrl,
    input  logic [31:0]        i_seed,
    output mzg_pkg::t_order    o_order
);
    import mzg_pkg::*;

    logic [31:0] r_lfsr;
    t_order      r_order;
    logic [31:0] n_lfsr;
    t_order      n_order;
    logic [1:0]  w_pick;
    logic [1:0]  w_swap;

    // four dependent draws, each one lfsr step and one swap
    always_comb begin
        n_lfsr  = r_lfsr;
        n_order = r_order;
        w_pick  = '0;
        w_swap  = '0;
        for (int i = 0; i < 4; i++) begin
            n_lfsr     = {1'b0, n_lfsr[31:1]} ^ (n_lfsr[0] ? LFSR_MASK : 32'h0);
            w_pick     = n_lfsr[1:0];
            w_swap     = n_order[i];
            n_order[i] = n_order[w_pick];
            n_order[w_pick] = w_swap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= '0;
            r_order <= ORDER_RESET;
        end else if (i_ctrl.load) begin
            r_lfsr <= i_seed;
        end else if (i_ctrl.mix) begin
            r_lfsr  <= n_lfsr;
            r_order <= n_order;
        end
    end

    assign o_order = r_order;

endmodule

[rtl/maze_generator_dfs_top.sv]
// ----------------------------------------------------------------------------
// maze_generator_dfs_top
// depth-first maze generator: one seed in, one wall bitmap per row out
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  seed     | in        | i_valid / o_stall    | i_seed
//  row      | out       | o_valid / i_stall    | o_row_index, o_row_bits, o_last
//
//  one seed transaction yields SIZE row transactions, row 0 first
//  a maze runs: accept, clear of every row, then the walk (each try checks
//    bounds, an in-bounds try reads the grid, a vertical carve writes the
//    wall row too, a backtrack pops a frame), then each row is read and sent
//  reset is synchronous, active low; the direction order survives between mazes
//  o_stall is high from acceptance until the last row transaction completes
//  a stalled row holds in the output register until taken
//
module maze_generator_dfs_top #(
    parameter int SIZE = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_row_index,
    output logic [14:0] o_row_bits,
    output logic        o_last
);
    import mzg_pkg::*;

    // cell coordinate width, stack geometry
    localparam int RW   = $clog2(SIZE);
    localparam int HALF = (SIZE - 1) / 2;
    localparam int CAP  = HALF * HALF + 1;
    localparam int SW   = $clog2(CAP);
    localparam int DW   = $clog2(CAP + 1);
    localparam int FW   = 2 * RW + 3;

    localparam logic [RW-1:0] LAST_ROW = RW'(SIZE - 1);
    localparam logic [RW-1:0] LIM_HI   = RW'(SIZE - 3);  // highest row/col that can step +2
    localparam logic [RW-1:0] EXIT_ROW = RW'(SIZE - 2);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [RW-1:0]   r_cnt, n_cnt;          // clear / readout row counter
    logic [DW-1:0]   r_depth, n_depth;      // frames including the top one
    logic [RW-1:0]   r_top_row, n_top_row;  // top frame is held in registers
    logic [RW-1:0]   r_top_col, n_top_col;
    logic [2:0]      r_top_idx, n_top_idx;
    logic [RW-1:0]   r_nr, n_nr;            // candidate cell under test
    logic [RW-1:0]   r_nc, n_nc;
    t_dir            r_dir, n_dir;

    logic            r_out_valid, n_out_valid;
    logic [3:0]      r_out_idx, n_out_idx;
    logic [14:0]     r_out_bits, n_out_bits;
    logic            r_out_last, n_out_last;

    // grid memory, one row per entry, bit = column, 1 = open
    logic [SIZE-1:0] r_grid [SIZE];
    logic [SIZE-1:0] r_grid_rdata;
    logic            w_grid_we;
    logic [RW-1:0]   w_grid_waddr;
    logic [SIZE-1:0] w_grid_wdata;
    logic [RW-1:0]   w_grid_raddr;

    // frame stack memory below the top frame: {row, col, loop index}
    logic [FW-1:0]   r_stack [CAP];
    logic [FW-1:0]   r_stack_rdata;
    logic            w_stk_we;
    logic [SW-1:0]   w_stk_waddr;
    logic [SW-1:0]   w_stk_raddr;

    t_shuf_ctrl      w_shuf;
    t_order          w_order;

    t_dir            w_try_dir;
    logic            w_in_bounds;
    logic [RW-1:0]   w_try_row;
    logic [RW-1:0]   w_try_col;
    logic [RW-1:0]   w_mid_row;
    logic [RW-1:0]   w_mid_col;
    logic [SIZE-1:0] w_row_view;
    logic [SIZE+14:0] w_row_ext;
    logic [RW+3:0]   w_idx_ext;

    // ------------------------------------------------------------------
    // random generator and shared direction order
    // ------------------------------------------------------------------
    mzg_shuffle u_shuffle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_shuf),
        .i_seed  (i_seed),
        .o_order (w_order)
    );

    // ------------------------------------------------------------------
    // memories: synchronous write, registered read
    // a read of a row in the cycle it is written is never used by the sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_grid_we) begin
            r_grid[w_grid_waddr] <= w_grid_wdata;
        end
        r_grid_rdata <= r_grid[w_grid_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack[w_stk_waddr] <= {r_top_row, r_top_col, r_top_idx};
        end
        r_stack_rdata <= r_stack[w_stk_raddr];
    end

    // ------------------------------------------------------------------
    // candidate step from the top frame
    // ------------------------------------------------------------------
    always_comb begin
        w_try_dir = t_dir'(w_order[r_top_idx[1:0]]);
        w_try_row = r_top_row;
        w_try_col = r_top_col;
        w_in_bounds = 1'b0;
        unique case (w_try_dir)
            DIR_UP: begin
                w_try_row   = r_top_row - RW'(2);
                w_in_bounds = (r_top_row >= RW'(2));
            end
            DIR_DOWN: begin
                w_try_row   = r_top_row + RW'(2);
                w_in_bounds = (r_top_row <= LIM_HI);
            end
            DIR_LEFT: begin
                w_try_col   = r_top_col - RW'(2);
                w_in_bounds = (r_top_col >= RW'(2));
            end
            DIR_RIGHT: begin
                w_try_col   = r_top_col + RW'(2);
                w_in_bounds = (r_top_col <= LIM_HI);
            end
            default: begin
                w_in_bounds = 1'b0;
            end
        endcase
    end

    // wall cell between parent and child
    assign w_mid_row = (r_dir == DIR_UP)   ? r_nr + RW'(1) : r_nr - RW'(1);
    assign w_mid_col = (r_dir == DIR_LEFT) ? r_nc + RW'(1) : r_nc - RW'(1);

    // readout view: add entrance and exit openings
    always_comb begin
        w_row_view = r_grid_rdata;
        if (r_cnt == RW'(1)) begin
            w_row_view = w_row_view | SIZE'(1);
        end
        if (r_cnt == EXIT_ROW) begin
            w_row_view = w_row_view | (SIZE'(1) << LAST_ROW);
        end
    end

    assign w_row_ext = {15'b0, w_row_view};
    assign w_idx_ext = {4'b0, r_cnt};

    // ------------------------------------------------------------------
    // sequencer: next state and memory controls
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_depth     = r_depth;
        n_top_row   = r_top_row;
        n_top_col   = r_top_col;
        n_top_idx   = r_top_idx;
        n_nr        = r_nr;
        n_nc        = r_nc;
        n_dir       = r_dir;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_bits  = r_out_bits;
        n_out_last  = r_out_last;

        w_grid_we    = 1'b0;
        w_grid_waddr = r_cnt;
        w_grid_wdata = '0;
        w_grid_raddr = r_cnt;
        w_stk_we     = 1'b0;
        w_stk_waddr  = SW'(r_depth - DW'(1));
        w_stk_raddr  = SW'(r_depth - DW'(2));
        w_shuf       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_shuf.load = 1'b1;
                    n_cnt       = '0;
                    n_state     = ST_CLEAR;
                end
            end

            // all walls, except the start cell which is opened on the way
            ST_CLEAR: begin
                w_grid_we    = 1'b1;
                w_grid_waddr = r_cnt;
                w_grid_wdata = (r_cnt == RW'(1)) ? SIZE'(2) : '0;
                if (r_cnt == LAST_ROW) begin
                    w_shuf.mix = 1'b1;
                    n_top_row  = RW'(1);
                    n_top_col  = RW'(1);
                    n_top_idx  = '0;
                    n_depth    = DW'(1);
                    n_state    = ST_STEP;
                end else begin
                    n_cnt = r_cnt + RW'(1);
                end
            end

            ST_STEP: begin
                if (r_top_idx[2]) begin
                    // frame exhausted: backtrack or finish
                    if (r_depth == DW'(1)) begin
                        n_cnt   = '0;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_depth = r_depth - DW'(1);
                        n_state = ST_POP;
                    end
                end else begin
                    n_top_idx = r_top_idx + 3'd1;
                    if (w_in_bounds) begin
                        w_grid_raddr = w_try_row;
                        n_nr    = w_try_row;
                        n_nc    = w_try_col;
                        n_dir   = w_try_dir;
                        n_state = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                if (r_grid_rdata[r_nc]) begin
                    n_state = ST_STEP;
                end else begin
                    // open child; horizontal wall shares its row
                    w_grid_we    = 1'b1;
                    w_grid_waddr = r_nr;
                    w_grid_wdata = r_grid_rdata | (SIZE'(1) << r_nc);
                    if (r_dir == DIR_LEFT || r_dir == DIR_RIGHT) begin
                        w_grid_wdata = w_grid_wdata | (SIZE'(1) << w_mid_col);
                        n_state      = ST_STEP;
                    end else begin
                        w_grid_raddr = w_mid_row;
                        n_state      = ST_MID;
                    end
                    // push parent, child becomes top
                    w_stk_we   = 1'b1;
                    w_shuf.mix = 1'b1;
                    n_top_row  = r_nr;
                    n_top_col  = r_nc;
                    n_top_idx  = '0;
                    n_depth    = r_depth + DW'(1);
                end
            end

            ST_MID: begin
                w_grid_we    = 1'b1;
                w_grid_waddr = w_mid_row;
                w_grid_wdata = r_grid_rdata | (SIZE'(1) << r_nc);
                n_state      = ST_STEP;
            end

            ST_POP: begin
                {n_top_row, n_top_col, n_top_idx} = r_stack_rdata;
                n_state = ST_STEP;
            end

            ST_OUT_RD: begin
                w_grid_raddr = r_cnt;
                n_state      = ST_OUT_LD;
            end

            ST_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_idx   = w_idx_ext[3:0];
                n_out_bits  = w_row_ext[14:0];
                n_out_last  = (r_cnt == LAST_ROW);
                n_state     = ST_OUT_WAIT;
            end

            ST_OUT_WAIT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + RW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_top_idx   <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_top_idx   <= n_top_idx;
            r_cnt       <= n_cnt;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_top_row  <= n_top_row;
        r_top_col  <= n_top_col;
        r_nr       <= n_nr;
        r_nc       <= n_nc;
        r_dir      <= n_dir;
        r_out_idx  <= n_out_idx;
        r_out_bits <= n_out_bits;
        r_out_last <= n_out_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_row_index = r_out_idx;
    assign o_row_bits  = r_out_bits;
    assign o_last      = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the walk always has a top frame while carving
    a_depth_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP || r_state == ST_CHECK || r_state == ST_POP)
            |-> (r_depth != '0))
        else $error("frame stack empty during carving");

    // loop index never runs past four directions
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> (r_top_idx <= 3'd4))
        else $error("loop index out of range");

    // no new seed is taken while rows are still pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("seed input open while a row is pending");

    // the last row ends the maze and frees the input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (!o_stall && !o_valid))
        else $error("block not idle after last row");

endmodule
